@@ rtl/core/mru_contact_bucket_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the contact bucket sequencer (mcb_ctrl).
// ---------------------------------------------------------------------------
`ifndef MRU_CONTACT_BUCKET_DEFINES_SVH
`define MRU_CONTACT_BUCKET_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("contact bucket assertion failed");

// Next-cycle implication, disabled during reset.
`define MCB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("contact bucket assertion failed");

`endif

@@ rtl/core/mcb_pkg.sv @@
// ---------------------------------------------------------------------------
// mcb_pkg
// Sizes, codes and shared types of the contact bucket.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcb_pkg;

  localparam int BUCKET_SLOTS = 20;
  localparam int ID_BITS      = 64;
  localparam int DATA_BITS    = 48;
  localparam int POS_W        = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

  // Operation codes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } mcb_state_t;

  // Update control broadcast to every cell
  typedef struct packed {
    logic             upd;
    logic             remove;
    logic             hit;
    logic [POS_W-1:0] pos;
  } mcb_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/mcb_cell.sv @@
// ---------------------------------------------------------------------------
// mcb_cell
// One contact slot: compares its id with the key and, on update, takes the
// neighbor's contents from above (push) or below (remove).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcb_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [mcb_pkg::POS_W-1:0]    idx,
  input  wire mcb_pkg::mcb_ctrl_t           ctrl,
  input  wire logic [mcb_pkg::ID_BITS-1:0]  key,
  input  wire logic [mcb_pkg::ID_BITS-1:0]  prev_id,
  input  wire logic [mcb_pkg::DATA_BITS-1:0] prev_data,
  input  wire logic [mcb_pkg::ID_BITS-1:0]  next_id,
  input  wire logic [mcb_pkg::DATA_BITS-1:0] next_data,
  output logic                              match,
  output logic [mcb_pkg::ID_BITS-1:0]       slot_id,
  output logic [mcb_pkg::DATA_BITS-1:0]     slot_data,
  output logic [mcb_pkg::ID_BITS-1:0]       slot_id_next,
  output logic [mcb_pkg::DATA_BITS-1:0]     slot_data_next
);
  import mcb_pkg::*;

  logic take_prev;
  logic take_next;

  // Compare against the key
  assign match = (slot_id == key);

  // Push shifts this slot down when it lies at or above the hit position, or on a miss
  assign take_prev = ctrl.upd && !ctrl.remove && (!ctrl.hit || (idx <= ctrl.pos));
  // Remove closes the gap from the hit position onward
  assign take_next = ctrl.upd && ctrl.remove && (idx >= ctrl.pos);

  always_comb begin
    slot_id_next   = slot_id;
    slot_data_next = slot_data;
    if (take_prev) begin
      slot_id_next   = prev_id;
      slot_data_next = prev_data;
    end else if (take_next) begin
      slot_id_next   = next_id;
      slot_data_next = next_data;
    end
  end

  // Hold the slot; reset empties it
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_id   <= '0;
      slot_data <= '0;
    end else begin
      slot_id   <= slot_id_next;
      slot_data <= slot_data_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mcb_ctrl.sv @@
// ---------------------------------------------------------------------------
// mcb_ctrl
// Sequencer: captures a transaction, encodes the hit position from the cell
// match flags and issues the one-cycle update to the chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mru_contact_bucket_defines.svh"

module mcb_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              operation,
  input  wire logic [63:0]                       contact_id,
  input  wire logic [mcb_pkg::DATA_BITS-1:0]     contact_data,
  input  wire logic [mcb_pkg::BUCKET_SLOTS-1:0]  match,
  input  wire logic                              out_busy,
  output logic [mcb_pkg::ID_BITS-1:0]            key,
  output logic [mcb_pkg::DATA_BITS-1:0]          key_data,
  output mcb_pkg::mcb_ctrl_t                     ctrl,
  output logic                                   load_result
);
  import mcb_pkg::*;

  mcb_state_t       state;
  mcb_state_t       state_next;
  logic             remove;
  logic             hit;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_enc;
  logic             key_nz;
  logic             go;
  logic             accept;

  assign key_nz = (key != '0);
  assign accept = in_valid && !in_stall;

  // Encode the one-hot match vector; empty slots never match a nonzero key
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      if (match[i]) begin
        pos_enc = pos_enc | POS_W'(i);
      end
    end
  end

  // Next state and handshake
  always_comb begin
    state_next  = state;
    go          = 1'b0;
    in_stall    = 1'b1;
    load_result = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        go          = !out_busy;
        in_stall    = out_busy;
        load_result = go;
        if (go) begin
          state_next = in_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive the cell update
  always_comb begin
    ctrl.remove = remove;
    ctrl.hit    = hit;
    ctrl.pos    = pos;
    if (remove) begin
      ctrl.upd = go && hit;
    end else begin
      ctrl.upd = go && key_nz && !(hit && (pos == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      remove   <= (operation == OP_REMOVE);
      key      <= contact_id[ID_BITS-1:0];
      key_data <= contact_data;
    end
  end

  // Register the lookup result
  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      hit <= key_nz && (match != '0);
      pos <= pos_enc;
    end
  end

  `MCB_ASSERT_IMP(a_match_unique, (state == ST_CMP) && key_nz, $onehot0(match))
  `MCB_ASSERT_NXT(a_accept_to_cmp, accept, state == ST_CMP)
  `MCB_ASSERT_NXT(a_cmp_to_upd, state == ST_CMP, state == ST_UPD)
  `MCB_ASSERT_NXT(a_upd_holds, (state == ST_UPD) && out_busy, state == ST_UPD)

endmodule

`default_nettype wire

@@ rtl/core/mru_contact_bucket.sv @@
// ---------------------------------------------------------------------------
// mru_contact_bucket
// Most-recently-seen contact bucket built as a chain of slot cells.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | operation, contact_id, contact_data
//  out     | out_valid/out_stall | found, tail_valid, tail_id, tail_data
//
//  A transaction runs in two states: ST_CMP compares the key in every cell
//  and encodes the hit position, ST_UPD shifts the chain and loads the result.
//  The next transaction is taken in the update state, so a new item is
//  accepted as the previous result is loaded into the result register.
//  A result still held by out_stall holds the update cycle and input.
//  Synchronous reset empties all slots.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mru_contact_bucket (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          operation,
  input  wire logic [63:0]                   contact_id,
  input  wire logic [mcb_pkg::DATA_BITS-1:0] contact_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               found,
  output logic                               tail_valid,
  output logic [63:0]                        tail_id,
  output logic [mcb_pkg::DATA_BITS-1:0]      tail_data
);
  import mcb_pkg::*;

  logic [BUCKET_SLOTS-1:0] match;
  logic [ID_BITS-1:0]      key;
  logic [DATA_BITS-1:0]    key_data;
  mcb_ctrl_t               ctrl;
  logic                    load_result;
  logic                    out_busy;

  logic [ID_BITS-1:0]      cell_id        [BUCKET_SLOTS];
  logic [DATA_BITS-1:0]    cell_data      [BUCKET_SLOTS];
  logic [ID_BITS-1:0]      cell_id_next   [BUCKET_SLOTS];
  logic [DATA_BITS-1:0]    cell_data_next [BUCKET_SLOTS];

  assign out_busy = out_valid && out_stall;

  mcb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .contact_id   (contact_id),
    .contact_data (contact_data),
    .match        (match),
    .out_busy     (out_busy),
    .key          (key),
    .key_data     (key_data),
    .ctrl         (ctrl),
    .load_result  (load_result)
  );

  // Build the slot chain; the head takes the key, the tail pulls in empty
  for (genvar i = 0; i < BUCKET_SLOTS; i++) begin : g_cell
    logic [ID_BITS-1:0]   prev_id;
    logic [DATA_BITS-1:0] prev_data;
    logic [ID_BITS-1:0]   next_id;
    logic [DATA_BITS-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_id   = key;
      assign prev_data = key_data;
    end else begin : g_mid_prev
      assign prev_id   = cell_id[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == BUCKET_SLOTS - 1) begin : g_tail
      assign next_id   = '0;
      assign next_data = '0;
    end else begin : g_mid_next
      assign next_id   = cell_id[i+1];
      assign next_data = cell_data[i+1];
    end

    mcb_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .idx            (POS_W'(i)),
      .ctrl           (ctrl),
      .key            (key),
      .prev_id        (prev_id),
      .prev_data      (prev_data),
      .next_id        (next_id),
      .next_data      (next_data),
      .match          (match[i]),
      .slot_id        (cell_id[i]),
      .slot_data      (cell_data[i]),
      .slot_id_next   (cell_id_next[i]),
      .slot_data_next (cell_data_next[i])
    );
  end

  // Result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload from the tail slot after the update
  always_ff @(posedge clk) begin
    if (load_result) begin
      found      <= ctrl.hit;
      tail_valid <= (cell_id_next[BUCKET_SLOTS-1] != '0);
      tail_id    <= 64'(cell_id_next[BUCKET_SLOTS-1]);
      tail_data  <= cell_data_next[BUCKET_SLOTS-1];
    end
  end

endmodule

`default_nettype wire
